// File: sv/reaction_propensity_engine_assert.svh
// ----------------------------------------------------------------------------
// Reaction propensity engine assertion macros
// Shorthand for clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REACTION_PROPENSITY_ENGINE_ASSERT_SVH
`define REACTION_PROPENSITY_ENGINE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define RPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/rpe_pkg.sv
// ----------------------------------------------------------------------------
// Reaction propensity engine package
// Sizes, stream field layout, request codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  // Capacity of the engine.
  localparam int MAX_REACTIONS = 64;
  localparam int MAX_SPECIES   = 16;
  localparam int COUNT_BITS    = 16;

  // Fixed field widths of the stream items.
  localparam int KIND_W  = 3;
  localparam int RXF_W   = 6;
  localparam int SXF_W   = 4;
  localparam int STO_W   = 4;
  localparam int RATE_W  = 24;
  localparam int CNTF_W  = 16;
  localparam int ACC_W   = 48;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // Derived storage geometry.
  localparam int CELLS  = MAX_REACTIONS * MAX_SPECIES;
  localparam int RX_W   = (MAX_REACTIONS > 1) ? $clog2(MAX_REACTIONS) : 1;
  localparam int SX_W   = (MAX_SPECIES > 1) ? $clog2(MAX_SPECIES) : 1;
  localparam int SXC_W  = $clog2(MAX_SPECIES + 1);
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [KIND_W-1:0] {
    REQ_STOICH = 3'd0,
    REQ_RATE   = 3'd1,
    REQ_COUNT  = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_EXEC   = 3'd4
  } req_e;

  typedef struct packed {
    logic [STO_W-1:0] prod;
    logic [STO_W-1:0] req;
  } stoich_t;

  typedef struct packed {
    req_e              kind;
    logic [RXF_W-1:0]  rx;
    logic [SXF_W-1:0]  sx;
    logic [STO_W-1:0]  req;
    logic [STO_W-1:0]  prod;
    logic [RATE_W-1:0] rate;
    logic [CNTF_W-1:0] count;
  } item_t;

endpackage

`default_nettype wire

// File: sv/rpe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/reaction_propensity_engine.sv
// ----------------------------------------------------------------------------
// Reaction propensity engine
// Mass-action propensity and firing engine for stochastic reaction networks.
// ----------------------------------------------------------------------------
// The engine keeps a molecule count per species, a Q8.16 rate per reaction
// and a requirement/product pair per reaction and species, each in its own
// RAM with a registered read. Every accepted transfer on the input stream
// yields exactly one transfer on the output stream. A write passes through
// the write and done states before its result shows on the output. A query
// or an execute reads its rate in the rate state, then walks the species
// one per cycle through the stoichiometry and count RAMs in the walk state;
// the walk is set by the single read port of those RAMs and by the one
// multiply per species that feeds the running Q32.16 product. In both cases
// the next input transfer can be taken in the same cycle as the result
// shows, and no new item is taken until the last one has left the done state.
// A query multiplies the rate by the count of every species with a nonzero
// requirement (once per species), clamps to all ones with the saturated
// flag, and answers zero when a count is short. An execute adds product
// minus requirement to each count, clamping at zero with the underflow flag
// and at the count maximum without a flag. After reset the engine clears
// the stoichiometry RAM and the counts in one pass over all MAX_REACTIONS *
// MAX_SPECIES entries, during which tready stays low. A new item is taken
// while a finished result still waits on the output. Rates read before they
// are written return undefined values.
// ----------------------------------------------------------------------------
`default_nettype none

module reaction_propensity_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream.
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0: reaction_index[5:0], species_index[9:6],
  // requirement[13:10], product[17:14], rate_value[41:18],
  // count_value[57:42], zero fill [63:58].
  input  wire logic [rpe_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0: req_type[2:0].
  input  wire logic [rpe_pkg::KIND_W-1:0]      s_axis_tuser_i,
  // Output stream.
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // Fields from bit 0: propensity[47:0].
  output logic      [rpe_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // Fields from bit 0: saturated[0], underflow[1].
  output logic      [rpe_pkg::OUT_USER_W-1:0]  m_axis_tuser_o
);

  localparam int CB    = rpe_pkg::COUNT_BITS;
  localparam int ACC_W = rpe_pkg::ACC_W;
  localparam int MUL_W = ACC_W + CB;
  localparam int EXW   = CB + 1;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_RATE  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Address of one stoichiometry entry: reaction row, species column.
  function automatic logic [rpe_pkg::CELL_W-1:0] cell_addr(logic [31:0] rx, logic [31:0] sx);
    return rpe_pkg::CELL_W'(rx * rpe_pkg::MAX_SPECIES + sx);
  endfunction

  logic [2:0]                  state_q, state_d;
  logic [rpe_pkg::CELL_W-1:0]  clr_q, clr_d;
  rpe_pkg::item_t              item_q, item_d;
  rpe_pkg::item_t              in_item;
  logic [rpe_pkg::SXC_W-1:0]   sc_q, sc_d;
  logic                        proc_v_q, proc_v_d;
  logic [rpe_pkg::SX_W-1:0]    proc_s_q, proc_s_d;
  logic [ACC_W-1:0]            acc_q, acc_d;
  logic                        sat_q, sat_d;
  logic                        short_q, short_d;
  logic                        under_q, under_d;
  logic                        out_valid_q, out_valid_d;
  logic [ACC_W-1:0]            out_prop_q, out_prop_d;
  logic                        out_sat_q, out_sat_d;
  logic                        out_under_q, out_under_d;

  logic                        in_xfer;
  logic                        in_rx_ok;
  logic                        rx_ok;
  logic                        sx_ok;
  logic                        clearing;
  logic                        issue;
  logic                        out_free;
  logic                        is_query;

  // RAM ports.
  logic                        st_we;
  logic [rpe_pkg::CELL_W-1:0]  st_waddr, st_raddr;
  rpe_pkg::stoich_t            st_wdata, st_rdata;
  logic                        cnt_we;
  logic [rpe_pkg::SX_W-1:0]    cnt_waddr, cnt_raddr;
  logic [CB-1:0]               cnt_wdata, cnt_rdata;
  logic                        rate_we;
  logic [rpe_pkg::RX_W-1:0]    rate_addr;
  logic [rpe_pkg::RATE_W-1:0]  rate_rdata;

  // Per-species datapath.
  logic [CB-1:0]               need;
  logic [MUL_W-1:0]            mul;
  logic [EXW-1:0]              ex_sum, ex_diff;
  logic                        ex_under;
  logic [CB-1:0]               ex_next;

  // Unpack the input transfer.
  assign in_item.kind  = rpe_pkg::req_e'(s_axis_tuser_i);
  assign in_item.rx    = s_axis_tdata_i[5:0];
  assign in_item.sx    = s_axis_tdata_i[9:6];
  assign in_item.req   = s_axis_tdata_i[13:10];
  assign in_item.prod  = s_axis_tdata_i[17:14];
  assign in_item.rate  = s_axis_tdata_i[41:18];
  assign in_item.count = s_axis_tdata_i[57:42];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_rx_ok        = (32'(in_item.rx) < rpe_pkg::MAX_REACTIONS);
  assign rx_ok           = (32'(item_q.rx) < rpe_pkg::MAX_REACTIONS);
  assign sx_ok           = (32'(item_q.sx) < rpe_pkg::MAX_SPECIES);
  assign clearing        = (state_q == ST_CLEAR);
  assign issue           = (state_q == ST_WALK) &&
                           (sc_q < rpe_pkg::SXC_W'(rpe_pkg::MAX_SPECIES));
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign is_query        = (item_q.kind == rpe_pkg::REQ_QUERY);

  // Stoichiometry RAM: cleared after reset, written by stoichiometry items,
  // read one species per cycle during a walk.
  assign st_we    = clearing ||
                    ((state_q == ST_WRITE) && (item_q.kind == rpe_pkg::REQ_STOICH) &&
                     rx_ok && sx_ok);
  assign st_waddr = clearing ? clr_q : cell_addr(32'(item_q.rx), 32'(item_q.sx));
  assign st_wdata = clearing ? '0 : {item_q.prod, item_q.req};
  assign st_raddr = cell_addr(32'(item_q.rx), 32'(sc_q));

  // Count RAM: the read for a species is issued in the cycle before its update
  // is written back, and each species is touched once per walk, so reads
  // and writes never meet on the same entry.
  assign cnt_we    = (clearing && (32'(clr_q) < rpe_pkg::MAX_SPECIES)) ||
                     ((state_q == ST_WRITE) && (item_q.kind == rpe_pkg::REQ_COUNT) && sx_ok) ||
                     (proc_v_q && (item_q.kind == rpe_pkg::REQ_EXEC));
  assign cnt_waddr = clearing ? rpe_pkg::SX_W'(clr_q) :
                     (state_q == ST_WRITE) ? rpe_pkg::SX_W'(item_q.sx) : proc_s_q;
  assign cnt_wdata = clearing ? '0 :
                     (state_q == ST_WRITE) ? CB'(item_q.count) : ex_next;
  assign cnt_raddr = rpe_pkg::SX_W'(sc_q);

  // Rate RAM: the address holds for the whole item, so the read issued in
  // the rate state is still on the output when the walk starts.
  assign rate_we   = (state_q == ST_WRITE) && (item_q.kind == rpe_pkg::REQ_RATE) && rx_ok;
  assign rate_addr = rpe_pkg::RX_W'(item_q.rx);

  rpe_ram #(
    .Width ($bits(rpe_pkg::stoich_t)),
    .Depth (rpe_pkg::CELLS)
  ) u_stoich_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  rpe_ram #(
    .Width (CB),
    .Depth (rpe_pkg::MAX_SPECIES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  rpe_ram #(
    .Width (rpe_pkg::RATE_W),
    .Depth (rpe_pkg::MAX_REACTIONS)
  ) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (rate_we),
    .waddr_i (rate_addr),
    .wdata_i (item_q.rate),
    .raddr_i (rate_addr),
    .rdata_o (rate_rdata)
  );

  // Per-species arithmetic on the registered RAM outputs.
  assign need = CB'(st_rdata.req);
  assign mul  = MUL_W'(acc_q) * MUL_W'(cnt_rdata);

  assign ex_sum   = EXW'(cnt_rdata) + EXW'(st_rdata.prod);
  assign ex_under = (ex_sum < EXW'(st_rdata.req));
  assign ex_diff  = ex_sum - EXW'(st_rdata.req);
  always_comb begin
    if (ex_under) begin
      ex_next = '0;
    end else if (ex_diff[CB]) begin
      ex_next = '1;
    end else begin
      ex_next = ex_diff[CB-1:0];
    end
  end

  // Sequencer and accumulators.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    sc_d        = sc_q;
    proc_v_d    = issue;
    proc_s_d    = rpe_pkg::SX_W'(sc_q);
    acc_d       = acc_q;
    sat_d       = sat_q;
    short_d     = short_q;
    under_d     = under_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_prop_d  = out_prop_q;
    out_sat_d   = out_sat_q;
    out_under_d = out_under_q;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == rpe_pkg::CELL_W'(rpe_pkg::CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          item_d  = in_item;
          sc_d    = '0;
          acc_d   = '0;
          sat_d   = 1'b0;
          short_d = 1'b0;
          under_d = 1'b0;
          unique case (in_item.kind)
            rpe_pkg::REQ_STOICH,
            rpe_pkg::REQ_RATE,
            rpe_pkg::REQ_COUNT: state_d = ST_WRITE;
            rpe_pkg::REQ_QUERY,
            rpe_pkg::REQ_EXEC:  state_d = in_rx_ok ? ST_RATE : ST_DONE;
            default:            state_d = ST_DONE;
          endcase
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_RATE: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (issue) begin
          sc_d = sc_q + 1'b1;
        end
        // The rate read lands in the first walk cycle and seeds the product.
        if (sc_q == '0) begin
          acc_d = ACC_W'(rate_rdata);
        end
        if (proc_v_q) begin
          if (is_query) begin
            if (need != '0) begin
              if (need > cnt_rdata) begin
                short_d = 1'b1;
              end else if (|mul[MUL_W-1:ACC_W]) begin
                acc_d = '1;
                sat_d = 1'b1;
              end else begin
                acc_d = mul[ACC_W-1:0];
              end
            end
          end else if (ex_under) begin
            under_d = 1'b1;
          end
        end
        if (!issue && !proc_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_prop_d  = (is_query && !short_q) ? acc_q : '0;
          out_sat_d   = is_query && !short_q && sat_q;
          out_under_d = (item_q.kind == rpe_pkg::REQ_EXEC) && under_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sc_q        <= '0;
      proc_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sc_q        <= sc_d;
      proc_v_q    <= proc_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    proc_s_q    <= proc_s_d;
    acc_q       <= acc_d;
    sat_q       <= sat_d;
    short_q     <= short_d;
    under_q     <= under_d;
    out_prop_q  <= out_prop_d;
    out_sat_q   <= out_sat_d;
    out_under_q <= out_under_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_prop_q;
  assign m_axis_tuser_o  = {out_under_q, out_sat_q};

endmodule

`default_nettype wire

// File: sv/rpe_checker.sv
// ----------------------------------------------------------------------------
// Reaction propensity engine port checker
// Concurrent checks on the stream ports of the engine, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reaction_propensity_engine_assert.svh"

module rpe_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [rpe_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input wire logic [rpe_pkg::OUT_USER_W-1:0]  m_axis_tuser_o
);

  // A stalled result keeps its valid and its propensity.
  `RPE_ASSERT(a_out_hold,
              m_axis_tvalid_o && !m_axis_tready_i |=>
                m_axis_tvalid_o && $stable(m_axis_tdata_o),
              "stalled result changed")

  // Only queries saturate and only executes underflow, so both flags never show together.
  `RPE_ASSERT(a_flags_exclusive,
              m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]),
              "saturated and underflow both set")

  // A saturated propensity is clamped to all ones.
  `RPE_ASSERT(a_sat_clamped,
              m_axis_tvalid_o && m_axis_tuser_o[0] |-> (&m_axis_tdata_o),
              "saturated propensity not clamped")

  // The engine works on one item at a time.
  `RPE_ASSERT(a_one_at_a_time,
              s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o,
              "second input transfer while busy")

  // Once an edge has seen reset low, both streams are quiet after it.
  `RPE_ASSERT_ALWAYS(a_quiet_in_reset,
                     !rst_ni |=> !m_axis_tvalid_o && !s_axis_tready_o,
                     "stream active during reset")

endmodule

bind reaction_propensity_engine rpe_checker u_rpe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
